### hdl/hrlp_pkg.sv
package hrlp_pkg;

  typedef enum logic [3:0] {
    PH_METHOD,
    PH_SEP1,
    PH_URI,
    PH_SEP2,
    PH_PROTO,
    PH_MAJ0,
    PH_MAJ,
    PH_MIN0,
    PH_MIN,
    PH_TRAIL
  } phase_t;

  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_BAD_SYNTAX  = 3'd1;
  localparam logic [2:0] ST_BAD_METHOD  = 3'd2;
  localparam logic [2:0] ST_BAD_PROTO   = 3'd3;
  localparam logic [2:0] ST_BAD_VERSION = 3'd4;

  localparam int unsigned NUM_METHODS = 4;
  localparam int unsigned BUF_DEPTH   = 2;

  typedef struct packed {
    logic       uri_valid;
    logic [7:0] uri_char;
    logic       line_done;
    logic [2:0] status;
    logic [1:0] method_code;
  } result_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_word(input logic [7:0] c);
    return (c == 8'h5F) || is_digit(c) || (c >= 8'h41 && c <= 8'h5A) ||
           (c >= 8'h61 && c <= 8'h7A);
  endfunction

  function automatic logic is_crlf(input logic [7:0] c);
    return (c == 8'h0D) || (c == 8'h0A);
  endfunction

  function automatic logic [7:0] to_upper(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) ? (c - 8'h20) : c;
  endfunction

  // Method name characters; zero past the end of a name.
  function automatic logic [7:0] method_byte(input logic [1:0] k, input logic [2:0] pos);
    logic [7:0] b;
    b = 8'h00;
    case (k)
      2'd0: begin
        case (pos)
          3'd0: b = "G";
          3'd1: b = "E";
          3'd2: b = "T";
          default: b = 8'h00;
        endcase
      end
      2'd1: begin
        case (pos)
          3'd0: b = "H";
          3'd1: b = "E";
          3'd2: b = "A";
          3'd3: b = "D";
          default: b = 8'h00;
        endcase
      end
      2'd2: begin
        case (pos)
          3'd0: b = "P";
          3'd1: b = "O";
          3'd2: b = "S";
          3'd3: b = "T";
          default: b = 8'h00;
        endcase
      end
      default: begin
        case (pos)
          3'd0: b = "D";
          3'd1: b = "E";
          3'd2: b = "L";
          3'd3: b = "E";
          3'd4: b = "T";
          3'd5: b = "E";
          default: b = 8'h00;
        endcase
      end
    endcase
    return b;
  endfunction

  function automatic logic [2:0] method_len(input logic [1:0] k);
    logic [2:0] n;
    case (k)
      2'd0:    n = 3'd3;
      2'd1:    n = 3'd4;
      2'd2:    n = 3'd4;
      default: n = 3'd6;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] proto_byte(input logic [2:0] pos);
    logic [7:0] b;
    case (pos)
      3'd0:    b = "H";
      3'd1:    b = "T";
      3'd2:    b = "T";
      3'd3:    b = "P";
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] version_byte(input logic [1:0] pos);
    logic [7:0] b;
    case (pos)
      2'd0:    b = "1";
      2'd1:    b = ".";
      2'd2:    b = "1";
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

### hdl/hrlp_parse.sv
module hrlp_parse import hrlp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       take,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  output result_t    result
);

  phase_t                 phase, phase_next;
  logic [NUM_METHODS-1:0] method_candidates, method_candidates_next;
  logic [2:0]             token_position, token_position_next;
  logic                   protocol_match, protocol_match_next;
  logic [1:0]             version_position, version_position_next;
  logic                   version_match, version_match_next;
  logic                   syntax_error, syntax_error_next;

  always_comb begin
    logic       bad;
    logic       uri_out;
    logic       sp;
    logic [7:0] u;
    phase_next             = phase;
    method_candidates_next = method_candidates;
    token_position_next    = token_position;
    protocol_match_next    = protocol_match;
    version_position_next  = version_position;
    version_match_next     = version_match;
    syntax_error_next      = syntax_error;
    bad     = 1'b0;
    uri_out = 1'b0;
    sp      = is_space(data_byte);
    u       = to_upper(data_byte);
    result  = '0;

    if (!syntax_error) begin
      unique case (phase) inside
        PH_METHOD: begin
          if (is_word(data_byte)) begin
            for (int k = 0; k < NUM_METHODS; k++) begin
              if (method_byte(2'(k), token_position) != u) begin
                method_candidates_next[k] = 1'b0;
              end
            end
            if (token_position != 3'd7) token_position_next = token_position + 3'd1;
          end else if (sp && token_position != 3'd0) begin
            for (int k = 0; k < NUM_METHODS; k++) begin
              if (method_len(2'(k)) != token_position) method_candidates_next[k] = 1'b0;
            end
            phase_next = PH_SEP1;
          end else begin
            bad = 1'b1;
          end
        end
        PH_SEP1: begin
          if (!sp) begin
            phase_next = PH_URI;
            uri_out    = 1'b1;
          end
        end
        PH_URI: begin
          if (sp) phase_next = PH_SEP2;
          else uri_out = 1'b1;
        end
        PH_SEP2: begin
          if (is_word(data_byte)) begin
            phase_next          = PH_PROTO;
            token_position_next = 3'd1;
            if (proto_byte(3'd0) != u) protocol_match_next = 1'b0;
          end else if (!sp) begin
            bad = 1'b1;
          end
        end
        PH_PROTO: begin
          if (is_word(data_byte)) begin
            if (proto_byte(token_position) != u) protocol_match_next = 1'b0;
            if (token_position != 3'd7) token_position_next = token_position + 3'd1;
          end else if (data_byte == "/") begin
            if (token_position != 3'd4) protocol_match_next = 1'b0;
            phase_next = PH_MAJ0;
          end else begin
            bad = 1'b1;
          end
        end
        PH_MAJ0, PH_MAJ, PH_MIN0, PH_MIN: begin
          if (is_digit(data_byte) ||
              (phase == PH_MAJ && data_byte == ".")) begin
            if (version_byte(version_position) != data_byte) version_match_next = 1'b0;
            if (version_position != 2'd3) begin
              version_position_next = version_position + 2'd1;
            end
            if (phase == PH_MAJ0) phase_next = PH_MAJ;
            else if (phase == PH_MIN0) phase_next = PH_MIN;
            else if (phase == PH_MAJ && data_byte == ".") phase_next = PH_MIN0;
          end else if (phase == PH_MIN && is_crlf(data_byte)) begin
            phase_next = PH_TRAIL;
          end else begin
            bad = 1'b1;
          end
        end
        PH_TRAIL: begin
          if (!is_crlf(data_byte)) bad = 1'b1;
        end
        default: bad = 1'b1;
      endcase
      if (bad) syntax_error_next = 1'b1;
    end

    result.uri_valid = uri_out;
    result.uri_char  = uri_out ? data_byte : 8'h00;
    result.line_done = last_byte;
    if (last_byte) begin
      if (syntax_error_next || (phase_next != PH_MIN && phase_next != PH_TRAIL)) begin
        result.status = ST_BAD_SYNTAX;
      end else if (method_candidates_next == '0) begin
        result.status = ST_BAD_METHOD;
      end else if (!protocol_match_next) begin
        result.status = ST_BAD_PROTO;
      end else if (!version_match_next || version_position_next != 2'd3) begin
        result.status = ST_BAD_VERSION;
      end else begin
        result.status = ST_OK;
        for (int k = NUM_METHODS - 1; k >= 0; k--) begin
          if (method_candidates_next[k]) result.method_code = 2'(k);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (take && last_byte)) begin
      phase             <= PH_METHOD;
      method_candidates <= '1;
      token_position    <= 3'd0;
      protocol_match    <= 1'b1;
      version_position  <= 2'd0;
      version_match     <= 1'b1;
      syntax_error      <= 1'b0;
    end else if (take) begin
      phase             <= phase_next;
      method_candidates <= method_candidates_next;
      token_position    <= token_position_next;
      protocol_match    <= protocol_match_next;
      version_position  <= version_position_next;
      version_match     <= version_match_next;
      syntax_error      <= syntax_error_next;
    end
  end

endmodule

### hdl/hrlp_out_buf.sv
module hrlp_out_buf import hrlp_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t push_data,
  output logic    full,
  output logic    out_valid,
  input  logic    out_stall,
  output result_t head
);

  localparam int unsigned CntW = $clog2(BUF_DEPTH + 1);

  logic [CntW-1:0] cnt;
  result_t         ent0, ent1;
  logic            pop;

  assign pop       = out_valid && !out_stall;
  assign out_valid = (cnt != '0);
  assign full      = (cnt == CntW'(BUF_DEPTH));
  assign head      = ent0;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (push && !pop) begin
      cnt <= cnt + CntW'(1);
    end else if (pop && !push) begin
      cnt <= cnt - CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push && pop) begin
      if (cnt == CntW'(1)) begin
        ent0 <= push_data;
      end else begin
        ent0 <= ent1;
        ent1 <= push_data;
      end
    end else if (push) begin
      if (cnt == '0) ent0 <= push_data;
      else ent1 <= push_data;
    end else if (pop) begin
      ent0 <= ent1;
    end
  end

endmodule

### hdl/http_request_line_parser_unit.sv
// HTTP request line parser: takes one byte of the request line per word,
// with last_byte set on the final byte, and returns exactly one result word
// per input word. URI bytes come out with uri_valid set; the result of the
// final byte carries line_done, the status (ok, bad syntax, unknown method,
// wrong protocol, unsupported version) and, when ok, the method code. The
// parser state updates in the cycle a word is accepted, so a new byte is
// taken every cycle while the output buffer has room; results wait in that
// two-word buffer, and in_stall rises only when it is full. Each result is
// registered into the buffer when its byte is accepted. After the final
// byte the parser is back in its start state for the next line.
module http_request_line_parser_unit import hrlp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       uri_valid,
  output logic [7:0] uri_char,
  output logic       line_done,
  output logic [2:0] status,
  output logic [1:0] method_code
);

  logic    take;
  logic    full;
  result_t result;
  result_t head;

  assign in_stall = full;
  assign take     = in_valid && !full;

  hrlp_parse u_parse (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .data_byte (data_byte),
    .last_byte (last_byte),
    .result    (result)
  );

  hrlp_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (take),
    .push_data (result),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .head      (head)
  );

  assign uri_valid   = head.uri_valid;
  assign uri_char    = head.uri_char;
  assign line_done   = head.line_done;
  assign status      = head.status;
  assign method_code = head.method_code;

endmodule

### bench/hrlp_line_checker.sv
module hrlp_line_checker import hrlp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        uri_valid,
  input  logic [7:0]  uri_char,
  input  logic        line_done,
  input  logic [2:0]  status,
  input  logic [1:0]  method_code,
  output int unsigned mismatches,
  output int unsigned pending,
  output int unsigned lines_judged,
  output int unsigned lines_ok,
  output int unsigned uri_bytes
);

  localparam logic [1:0] M_GET    = 2'd0;
  localparam logic [1:0] M_HEAD   = 2'd1;
  localparam logic [1:0] M_POST   = 2'd2;
  localparam logic [1:0] M_DELETE = 2'd3;

  localparam string PROTO_TEXT   = "HTTP";
  localparam string VERSION_TEXT = "1.1";

  phase_t     lphase;
  logic [3:0] cands;
  logic [2:0] tpos;
  logic       pmatch;
  logic [1:0] vpos;
  logic       vmatch;
  logic       serr;

  result_t pending_results[$];

  initial begin
    mismatches   = 0;
    pending      = 0;
    lines_judged = 0;
    lines_ok     = 0;
    uri_bytes    = 0;
  end

  function automatic string method_name(input logic [1:0] k);
    case (k)
      M_GET:   return "GET";
      M_HEAD:  return "HEAD";
      M_POST:  return "POST";
      default: return "DELETE";
    endcase
  endfunction

  function automatic bit ws_char(input logic [7:0] c);
    return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic bit dec_char(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit tok_char(input logic [7:0] c);
    return c == "_" || dec_char(c) || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  function automatic bit eol_char(input logic [7:0] c);
    return c == 8'h0D || c == 8'h0A;
  endfunction

  function automatic logic [7:0] fold_upper(input logic [7:0] c);
    return (c >= "a" && c <= "z") ? c - 8'd32 : c;
  endfunction

  function automatic void clear_parser();
    lphase = PH_METHOD;
    cands  = 4'hF;
    tpos   = 3'd0;
    pmatch = 1'b1;
    vpos   = 2'd0;
    vmatch = 1'b1;
    serr   = 1'b0;
  endfunction

  function automatic void bump_tpos();
    if (tpos != 3'd7) tpos = tpos + 3'd1;
  endfunction

  function automatic void take_method_char(input logic [7:0] c);
    string name;
    for (int k = 0; k < NUM_METHODS; k++) begin
      name = method_name(k[1:0]);
      if (tpos >= name.len() || name[tpos] != fold_upper(c)) cands[k] = 1'b0;
    end
    bump_tpos();
  endfunction

  function automatic void take_proto_char(input logic [7:0] c);
    if (tpos >= 3'd4 || PROTO_TEXT[tpos] != fold_upper(c)) pmatch = 1'b0;
    bump_tpos();
  endfunction

  function automatic void take_version_char(input logic [7:0] c);
    if (vpos == 2'd3 || VERSION_TEXT[vpos] != c) vmatch = 1'b0;
    if (vpos != 2'd3) vpos = vpos + 2'd1;
  endfunction

  function automatic result_t parse_byte(input logic [7:0] c, input logic fin);
    result_t r;
    string   name;
    bit      bad;
    bit      sp;
    r   = '0;
    bad = 1'b0;
    sp  = ws_char(c);
    if (!serr) begin
      case (lphase)
        PH_METHOD: begin
          if (tok_char(c)) begin
            take_method_char(c);
          end else if (sp && tpos != 3'd0) begin
            for (int k = 0; k < NUM_METHODS; k++) begin
              name = method_name(k[1:0]);
              if (name.len() != tpos) cands[k] = 1'b0;
            end
            lphase = PH_SEP1;
          end else begin
            bad = 1'b1;
          end
        end
        PH_SEP1: begin
          if (!sp) begin
            lphase = PH_URI;
            r.uri_valid = 1'b1;
          end
        end
        PH_URI: begin
          if (sp) lphase = PH_SEP2;
          else r.uri_valid = 1'b1;
        end
        PH_SEP2: begin
          if (tok_char(c)) begin
            lphase = PH_PROTO;
            tpos = 3'd0;
            take_proto_char(c);
          end else if (!sp) begin
            bad = 1'b1;
          end
        end
        PH_PROTO: begin
          if (tok_char(c)) begin
            take_proto_char(c);
          end else if (c == "/") begin
            if (tpos != 3'd4) pmatch = 1'b0;
            lphase = PH_MAJ0;
          end else begin
            bad = 1'b1;
          end
        end
        PH_MAJ0: begin
          if (dec_char(c)) begin
            take_version_char(c);
            lphase = PH_MAJ;
          end else begin
            bad = 1'b1;
          end
        end
        PH_MAJ: begin
          if (dec_char(c)) begin
            take_version_char(c);
          end else if (c == ".") begin
            take_version_char(c);
            lphase = PH_MIN0;
          end else begin
            bad = 1'b1;
          end
        end
        PH_MIN0: begin
          if (dec_char(c)) begin
            take_version_char(c);
            lphase = PH_MIN;
          end else begin
            bad = 1'b1;
          end
        end
        PH_MIN: begin
          if (dec_char(c)) take_version_char(c);
          else if (eol_char(c)) lphase = PH_TRAIL;
          else bad = 1'b1;
        end
        PH_TRAIL: begin
          if (!eol_char(c)) bad = 1'b1;
        end
        default: bad = 1'b1;
      endcase
      if (bad) serr = 1'b1;
    end
    if (r.uri_valid) r.uri_char = c;
    if (fin) begin
      r.line_done = 1'b1;
      if (serr || (lphase != PH_MIN && lphase != PH_TRAIL)) begin
        r.status = ST_BAD_SYNTAX;
      end else if (cands == 4'h0) begin
        r.status = ST_BAD_METHOD;
      end else if (!pmatch) begin
        r.status = ST_BAD_PROTO;
      end else if (!vmatch || vpos != 2'd3) begin
        r.status = ST_BAD_VERSION;
      end else begin
        r.status = ST_OK;
        for (int k = NUM_METHODS - 1; k >= 0; k--) begin
          if (cands[k]) r.method_code = k[1:0];
        end
      end
      clear_parser();
    end
    return r;
  endfunction

  task automatic report(input string what, input logic [7:0] got, input logic [7:0] want);
    if (mismatches < 32) begin
      $display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
    end
    mismatches++;
  endtask

  always @(posedge clk) begin : watch
    result_t seen;
    result_t want;
    if (rst) begin
      pending_results.delete();
      clear_parser();
    end else begin
      if (in_valid && !in_stall) pending_results.push_back(parse_byte(data_byte, last_byte));
      if (out_valid && !out_stall) begin
        seen.uri_valid   = uri_valid;
        seen.uri_char    = uri_char;
        seen.line_done   = line_done;
        seen.status      = status;
        seen.method_code = method_code;
        if (pending_results.size() == 0) begin
          report("word with no byte waiting", seen.uri_char, 8'h00);
        end else begin
          want = pending_results.pop_front();
          if (seen.uri_valid !== want.uri_valid)
            report("uri_valid", 8'(seen.uri_valid), 8'(want.uri_valid));
          if (seen.uri_char !== want.uri_char)
            report("uri_char", seen.uri_char, want.uri_char);
          if (seen.line_done !== want.line_done)
            report("line_done", 8'(seen.line_done), 8'(want.line_done));
          if (seen.status !== want.status)
            report("status", 8'(seen.status), 8'(want.status));
          if (seen.method_code !== want.method_code)
            report("method_code", 8'(seen.method_code), 8'(want.method_code));
          if (want.line_done) lines_judged++;
          if (want.line_done && want.status == ST_OK) lines_ok++;
          if (want.uri_valid) uri_bytes++;
        end
      end
    end
    pending = pending_results.size();
  end

endmodule

### bench/http_request_line_parser_unit_test.sv
module http_request_line_parser_unit_test;

  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       in_valid  = 1'b0;
  logic [7:0] data_byte = 8'h00;
  logic       last_byte = 1'b0;
  logic       out_stall = 1'b0;

  logic       in_stall;
  logic       out_valid;
  logic       uri_valid;
  logic [7:0] uri_char;
  logic       line_done;
  logic [2:0] status;
  logic [1:0] method_code;

  int unsigned mismatches;
  int unsigned pending;
  int unsigned lines_judged;
  int unsigned lines_ok;
  int unsigned uri_bytes;

  int unsigned bytes_sent = 0;
  int unsigned stall_left = 0;
  bit          src_gaps   = 1'b0;
  bit          sink_gaps  = 1'b0;
  logic [7:0]  line_q[$];

  always #5 clk = ~clk;

  http_request_line_parser_unit u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .data_byte(data_byte), .last_byte(last_byte),
    .out_valid(out_valid), .out_stall(out_stall),
    .uri_valid(uri_valid), .uri_char(uri_char), .line_done(line_done),
    .status(status), .method_code(method_code)
  );

  hrlp_line_checker u_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .data_byte(data_byte), .last_byte(last_byte),
    .out_valid(out_valid), .out_stall(out_stall),
    .uri_valid(uri_valid), .uri_char(uri_char), .line_done(line_done),
    .status(status), .method_code(method_code),
    .mismatches(mismatches), .pending(pending),
    .lines_judged(lines_judged), .lines_ok(lines_ok), .uri_bytes(uri_bytes)
  );

  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else if (sink_gaps && $urandom_range(0, 9) == 0) begin
      stall_left <= $urandom_range(0, 12);
      out_stall  <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic fin);
    if (src_gaps && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    data_byte <= b;
    last_byte <= fin;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
  endtask

  task automatic send_line();
    for (int i = 0; i < line_q.size(); i++) send_byte(line_q[i], i == line_q.size() - 1);
    line_q.delete();
  endtask

  function automatic void add_text(input string s, input bit mixcase);
    logic [7:0] c;
    for (int i = 0; i < s.len(); i++) begin
      c = s[i];
      if (mixcase && c >= "A" && c <= "Z" && $urandom_range(0, 1)) c = c + 8'd32;
      line_q.push_back(c);
    end
  endfunction

  function automatic void add_word(input int n);
    int r;
    repeat (n) begin
      r = $urandom_range(0, 62);
      if (r < 10) line_q.push_back(8'("0" + r));
      else if (r < 36) line_q.push_back(8'("A" + r - 10));
      else if (r < 62) line_q.push_back(8'("a" + r - 36));
      else line_q.push_back("_");
    end
  endfunction

  function automatic void add_spaces(input int n);
    repeat (n) begin
      case ($urandom_range(0, 5))
        0:       line_q.push_back(8'h09);
        1:       line_q.push_back(8'h0A);
        2:       line_q.push_back(8'h0B);
        3:       line_q.push_back(8'h0C);
        4:       line_q.push_back(8'h0D);
        default: line_q.push_back(8'h20);
      endcase
    end
  endfunction

  function automatic void add_version_part();
    if ($urandom_range(0, 5) < 4) line_q.push_back("1");
    else repeat ($urandom_range(1, 3)) line_q.push_back(8'("0" + $urandom_range(0, 9)));
  endfunction

  function automatic void build_random_line();
    int         pick;
    int         cut;
    logic [7:0] c;
    pick = $urandom_range(0, 99);
    if (pick < 6) begin
      repeat ($urandom_range(1, 8)) line_q.push_back(8'($urandom_range(0, 255)));
      return;
    end
    if ($urandom_range(0, 4) != 0) begin
      case ($urandom_range(0, 3))
        0:       add_text("GET", 1'b1);
        1:       add_text("HEAD", 1'b1);
        2:       add_text("POST", 1'b1);
        default: add_text("DELETE", 1'b1);
      endcase
    end else begin
      add_word($urandom_range(1, 9));
    end
    add_spaces($urandom_range(1, 3));
    repeat ($urandom_range(1, 6)) begin
      do c = 8'($urandom_range(0, 255)); while (c == 8'h20 || (c >= 8'h09 && c <= 8'h0D));
      line_q.push_back(c);
    end
    add_spaces($urandom_range(1, 2));
    if ($urandom_range(0, 5) != 0) add_text("HTTP", 1'b1);
    else add_word($urandom_range(1, 6));
    line_q.push_back("/");
    add_version_part();
    line_q.push_back(".");
    add_version_part();
    repeat ($urandom_range(0, 2)) line_q.push_back($urandom_range(0, 1) ? 8'h0D : 8'h0A);
    // damage one byte, or end the line early
    if (pick < 18) begin
      line_q[$urandom_range(0, line_q.size() - 1)] = 8'($urandom_range(0, 255));
    end else if (pick < 26) begin
      cut = $urandom_range(1, line_q.size() - 1);
      while (line_q.size() > cut) line_q.delete(line_q.size() - 1);
    end
  endfunction

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    line_q.push_back(8'h00);
    send_line();
    line_q.push_back(8'hFF);
    send_line();
    add_text("g x", 1'b0);
    send_line();
    add_text("head /a http/1.1\n", 1'b0);
    send_line();

    while (bytes_sent < 600) begin
      if (bytes_sent < 500) begin
        src_gaps  <= $urandom_range(0, 2) != 0;
        sink_gaps <= $urandom_range(0, 2) != 0;
      end else begin
        src_gaps  <= 1'b0;
        sink_gaps <= 1'b0;
      end
      build_random_line();
      send_line();
    end
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Sent %0d bytes in lines with random content, damage and early ends.",
             bytes_sent);
    $display("Judged %0d lines (%0d accepted), passed %0d URI bytes.",
             lines_judged, lines_ok, uri_bytes);
    if (mismatches == 0 && pending == 0) begin
      $display("http_request_line_parser_unit_test: PASS");
    end else begin
      $display("http_request_line_parser_unit_test: FAIL");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Timed out with %0d words outstanding.", pending);
    $display("http_request_line_parser_unit_test: FAIL");
    $finish;
  end

endmodule
